[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes, character constants and keyword tables of the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int OFF_W  = 24;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 4;
  localparam int KW_N   = 5;

  localparam logic [KIND_W-1:0] TK_EOF    = 4'd0;
  localparam logic [KIND_W-1:0] TK_DEF    = 4'd1;
  localparam logic [KIND_W-1:0] TK_EXTERN = 4'd2;
  localparam logic [KIND_W-1:0] TK_IF     = 4'd3;
  localparam logic [KIND_W-1:0] TK_THEN   = 4'd4;
  localparam logic [KIND_W-1:0] TK_ELSE   = 4'd5;
  localparam logic [KIND_W-1:0] TK_IDENT  = 4'd6;
  localparam logic [KIND_W-1:0] TK_NUMBER = 4'd7;
  localparam logic [KIND_W-1:0] TK_OP     = 4'd8;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_US   = 8'h5F;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  localparam logic [7:0] KW_TEXT [0:KW_N-1][0:5] = '{
    '{8'h64, 8'h65, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h78, 8'h74, 8'h65, 8'h72, 8'h6E},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [0:KW_N-1] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd4};
  localparam logic [KIND_W-1:0] KW_KIND [0:KW_N-1] =
    '{TK_DEF, TK_EXTERN, TK_IF, TK_THEN, TK_ELSE};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  column;
    logic [7:0]        op;
  } tok_t;

  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } entry_t;

  typedef struct packed {
    logic pop;
  } q_ctl_t;

  function automatic logic kw_hit(input int k, input logic [2:0] pos,
                                  input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (pos < KW_LEN[k]) begin
      hit = (KW_TEXT[k][pos] == c);
    end
    return hit;
  endfunction

endpackage

[hdl/stt_front.sv]
// ----------------------------------------------------------------------------
// stt_front
// Byte classifier and scanner state: takes one source byte per cycle while
// accept is high; pushes the tokens it completes (one or two) as one entry.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       src_end,
  input  logic [7:0] src_byte,
  output logic       push,
  output entry_t     push_entry
);

  localparam int OFF_EXT_W = (OFFSET_BITS > OFF_W) ? OFFSET_BITS : OFF_W;
  localparam int POS_EXT_W = (POSITION_BITS > POS_W) ? POSITION_BITS : POS_W;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_DOT
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;
  logic [OFFSET_BITS-1:0]   st_off_r, st_off_nxt;
  logic [POSITION_BITS-1:0] st_line_r, st_line_nxt;
  logic [POSITION_BITS-1:0] st_col_r, st_col_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [KW_N-1:0]          cand_r, cand_nxt;

  logic [OFF_EXT_W-1:0] cur_off_ext, st_off_ext;
  logic [POS_EXT_W-1:0] cur_line_ext, cur_col_ext, st_line_ext, st_col_ext;

  logic              is_digit, is_alpha, is_ident, is_ws;
  logic [2:0]        kw_pos;
  logic [KW_N-1:0]   cand_ext, cand_first;
  logic [LEN_W-1:0]  len_inc;
  logic [KIND_W-1:0] id_kind;
  logic              flush, idle_proc, op_emit;
  tok_t              pend_tok, here_tok, eof_tok;

  assign cur_off_ext  = OFF_EXT_W'(off_r);
  assign st_off_ext   = OFF_EXT_W'(st_off_r);
  assign cur_line_ext = POS_EXT_W'(line_r);
  assign cur_col_ext  = POS_EXT_W'(col_r);
  assign st_line_ext  = POS_EXT_W'(st_line_r);
  assign st_col_ext   = POS_EXT_W'(st_col_r);

  assign is_digit = (src_byte >= 8'h30) && (src_byte <= 8'h39);
  assign is_alpha = ((src_byte >= 8'h61) && (src_byte <= 8'h7A)) ||
                    ((src_byte >= 8'h41) && (src_byte <= 8'h5A));
  assign is_ident = is_alpha || is_digit || (src_byte == CH_US);
  assign is_ws    = (src_byte == CH_SP) || (src_byte == CH_TAB) ||
                    (src_byte == CH_CR) || (src_byte == CH_NL);

  assign kw_pos  = (len_r < LEN_W'(6)) ? len_r[2:0] : 3'd7;
  assign len_inc = (&len_r) ? len_r : len_r + LEN_W'(1);

  always_comb begin
    for (int k = 0; k < KW_N; k++) begin
      cand_ext[k]   = cand_r[k] && kw_hit(k, kw_pos, src_byte);
      cand_first[k] = kw_hit(k, 3'd0, src_byte);
    end
  end

  always_comb begin
    id_kind = TK_IDENT;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (cand_r[k] && (len_r == LEN_W'(KW_LEN[k]))) begin
        id_kind = KW_KIND[k];
      end
    end
  end

  always_comb begin
    pend_tok.offset = st_off_ext[OFF_W-1:0];
    pend_tok.len    = len_r;
    pend_tok.line   = st_line_ext[POS_W-1:0];
    pend_tok.column = st_col_ext[POS_W-1:0];
    pend_tok.op     = 8'h00;
    unique case (mode_r)
      MODE_IDENT: pend_tok.kind = id_kind;
      MODE_DOT: begin
        pend_tok.kind = TK_OP;
        pend_tok.op   = CH_DOT;
      end
      default:    pend_tok.kind = TK_NUMBER;
    endcase

    here_tok.kind   = TK_OP;
    here_tok.offset = cur_off_ext[OFF_W-1:0];
    here_tok.len    = LEN_W'(1);
    here_tok.line   = cur_line_ext[POS_W-1:0];
    here_tok.column = cur_col_ext[POS_W-1:0];
    here_tok.op     = src_byte;

    eof_tok        = here_tok;
    eof_tok.kind   = TK_EOF;
    eof_tok.len    = '0;
    eof_tok.op     = 8'h00;
  end

  always_comb begin
    mode_nxt    = mode_r;
    off_nxt     = off_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    st_off_nxt  = st_off_r;
    st_line_nxt = st_line_r;
    st_col_nxt  = st_col_r;
    len_nxt     = len_r;
    cand_nxt    = cand_r;
    flush       = 1'b0;
    idle_proc   = 1'b0;
    op_emit     = 1'b0;

    if (src_end) begin
      flush    = (mode_r != MODE_IDLE) && (mode_r != MODE_COMMENT);
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_COMMENT: begin
          idle_proc = (src_byte == CH_NL);
        end
        MODE_IDENT: begin
          if (is_ident) begin
            cand_nxt = cand_ext;
            len_nxt  = len_inc;
          end else begin
            flush     = 1'b1;
            idle_proc = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit || (src_byte == CH_DOT)) begin
            if (src_byte == CH_DOT) begin
              mode_nxt = MODE_FRAC;
            end
            len_nxt = len_inc;
          end else begin
            flush     = 1'b1;
            idle_proc = 1'b1;
          end
        end
        MODE_FRAC, MODE_DOT: begin
          if (is_digit) begin
            mode_nxt = MODE_FRAC;
            len_nxt  = len_inc;
          end else begin
            flush     = 1'b1;
            idle_proc = 1'b1;
          end
        end
        default: idle_proc = 1'b1;
      endcase

      if (idle_proc) begin
        mode_nxt = MODE_IDLE;
        if (!is_ws) begin
          if (src_byte == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (is_alpha || is_digit || (src_byte == CH_US) ||
                       (src_byte == CH_DOT)) begin
            st_off_nxt  = off_r;
            st_line_nxt = line_r;
            st_col_nxt  = col_r;
            len_nxt     = LEN_W'(1);
            cand_nxt    = '1;
            if (is_digit) begin
              mode_nxt = MODE_INT;
            end else if (src_byte == CH_DOT) begin
              mode_nxt = MODE_DOT;
            end else begin
              mode_nxt = MODE_IDENT;
              cand_nxt = cand_first;
            end
          end else begin
            op_emit = 1'b1;
          end
        end
      end

      off_nxt = (&off_r) ? off_r : off_r + OFFSET_BITS'(1);
      if (src_byte == CH_NL) begin
        line_nxt = (&line_r) ? line_r : line_r + POSITION_BITS'(1);
        col_nxt  = POSITION_BITS'(1);
      end else begin
        col_nxt  = (&col_r) ? col_r : col_r + POSITION_BITS'(1);
      end
    end
  end

  always_comb begin
    push_entry.second = src_end ? eof_tok : here_tok;
    push_entry.first  = flush ? pend_tok : push_entry.second;
    push_entry.two    = flush && (src_end || op_emit);
    push              = accept && (src_end || flush || op_emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      off_r  <= '0;
      line_r <= POSITION_BITS'(1);
      col_r  <= POSITION_BITS'(1);
      cand_r <= '1;
      len_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      cand_r <= cand_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_off_r  <= st_off_nxt;
      st_line_r <= st_line_nxt;
      st_col_r  <= st_col_nxt;
    end
  end

endmodule

[hdl/stt_queue.sv]
// ----------------------------------------------------------------------------
// stt_queue
// Short FIFO of token entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  q_ctl_t ctl_in,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop        = ctl_in.pop;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

[hdl/stt_back.sv]
// ----------------------------------------------------------------------------
// stt_back
// Output stage: unpacks each queue entry into one or two token transfers
// and holds the current token in a register until the sink takes it.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   head_valid,
  input  entry_t head_entry,
  output q_ctl_t ctl_out,
  output logic   tok_valid,
  input  logic   tok_ready,
  output tok_t   tok,
  output logic   tok_last
);

  logic valid_r, last_r, half_r;
  tok_t tok_r;
  logic load;

  assign load          = head_valid && (!valid_r || tok_ready);
  assign ctl_out.pop   = load && (half_r || !head_entry.two);
  assign tok_valid     = valid_r;
  assign tok           = tok_r;
  assign tok_last      = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      half_r  <= !half_r && head_entry.two;
    end else if (tok_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= half_r ? head_entry.second : head_entry.first;
      last_r <= half_r || !head_entry.two;
    end
  end

`ifndef SYNTHESIS
  a_half_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> head_valid && head_entry.two)
    else $error("second token pending without a paired entry");
  a_notlast_pending: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !last_r |-> half_r)
    else $error("non-last token shown without its partner pending");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_out.pop |=> valid_r && last_r)
    else $error("entry popped without loading its last token");
`endif

endmodule

[hdl/source_text_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexer: source bytes in, tokens with position and length out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle with no bubbles as long as the token queue
// (QUEUE_DEPTH entries) has room. A byte yields zero, one or two tokens and
// the end-of-source item one or two; the output register sends one token per
// cycle while out_tready is high, so a byte that both ends a token and is
// itself an operator costs an extra output transfer, absorbed by the queue.
// Tokens go via the queue to the output register. No clearing pass after reset.
module source_text_tokenizer_top import stt_pkg::*; #(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [23:0] start_offset, [39:24] token_length, [55:40] start_line,
  // [71:56] start_column, [79:72] op_byte
  output logic [79:0] out_tdata,
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast
);

  logic   full, accept, push, head_valid;
  entry_t push_entry, head_entry;
  q_ctl_t q_ctl;
  tok_t   tok;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  stt_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .src_end    (in_tuser[0]),
    .src_byte   (in_tdata),
    .push       (push),
    .push_entry (push_entry)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .ctl_in     (q_ctl),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  stt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .ctl_out    (q_ctl),
    .tok_valid  (out_tvalid),
    .tok_ready  (out_tready),
    .tok        (tok),
    .tok_last   (out_tlast)
  );

  assign out_tdata = {tok.op, tok.column, tok.line, tok.len, tok.offset};
  assign out_tuser = tok.kind;

endmodule
